/* sv/rtc_pkg.sv */
package rtc_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_rtc_op;

    typedef enum logic [1:0] {
        CFG_RELOAD = 2'd0,
        CFG_ALARM  = 2'd1,
        CFG_IRQ_EN = 2'd2
    } t_cfg_idx;

    localparam int RELOAD_W  = 20;
    localparam int COUNTER_W = 32;
    localparam int FLAGS_W   = 3;
    localparam int CFG_W     = 32;

    // flag bit positions
    localparam int FLAG_ALARM    = 0;
    localparam int FLAG_SECOND   = 1;
    localparam int FLAG_OVERFLOW = 2;

    localparam logic [RELOAD_W-1:0]  RELOAD_RST = 20'd32767;
    localparam logic [COUNTER_W-1:0] ALARM_RST  = 32'hFFFF_FFFF;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

    // reciprocals: x/86400 = ((x>>7)*DAY_RECIP)>>35, exact for 32-bit x
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    // x/3600 = ((x>>4)*HOUR_RECIP)>>21, exact for x < 86400
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    // x/60 = ((x>>2)*MIN_RECIP)>>14, exact for x < 3600
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    typedef struct packed {
        logic [COUNTER_W-1:0] counter;
        logic [FLAGS_W-1:0]   flags;
        logic                 rtc_irq;
        logic                 alarm_irq;
    } t_rtc_meta;

endpackage

/* sv/rtc_core.sv */
module rtc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  rtc_pkg::t_cfg_idx              i_cfg_index,
    input  logic [rtc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_valid,
    input  rtc_pkg::t_rtc_op               i_op,
    input  logic [rtc_pkg::COUNTER_W-1:0]  i_load,
    input  logic [rtc_pkg::FLAGS_W-1:0]    i_mask,
    output logic                           o_ready,
    output logic                           o_valid,
    output rtc_pkg::t_rtc_meta             o_meta,
    input  logic                           i_ready
);
    import rtc_pkg::*;

    logic [RELOAD_W-1:0]  r_reload;
    logic [COUNTER_W-1:0] r_alarm;
    logic [FLAGS_W-1:0]   r_irq_en;

    logic [RELOAD_W-1:0]  r_divider, n_divider;
    logic [COUNTER_W-1:0] r_counter, n_counter;
    logic [FLAGS_W-1:0]   r_flags, n_flags;
    logic [COUNTER_W-1:0] stepped;
    logic [FLAGS_W-1:0]   active;

    logic      r_valid;
    t_rtc_meta r_meta;
    logic      accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= RELOAD_RST;
            r_alarm  <= ALARM_RST;
            r_irq_en <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RELOAD: r_reload <= i_cfg_wdata[RELOAD_W-1:0];
                CFG_ALARM:  r_alarm  <= i_cfg_wdata[COUNTER_W-1:0];
                CFG_IRQ_EN: r_irq_en <= i_cfg_wdata[FLAGS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_divider = r_divider;
        n_counter = r_counter;
        n_flags   = r_flags;
        stepped   = r_counter + COUNTER_W'(1);
        case (i_op)
            OP_TICK: begin
                if (r_divider == '0) begin
                    n_divider            = r_reload;
                    n_counter            = stepped;
                    n_flags[FLAG_SECOND] = 1'b1;
                    if (stepped == '0)
                        n_flags[FLAG_OVERFLOW] = 1'b1;
                    if (stepped == r_alarm)
                        n_flags[FLAG_ALARM] = 1'b1;
                end else begin
                    n_divider = r_divider - RELOAD_W'(1);
                end
            end
            OP_LOAD:  n_counter = i_load;
            OP_CLEAR: n_flags   = r_flags & ~i_mask;
            default: ;
        endcase
        active = n_flags & r_irq_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= RELOAD_RST;
            r_counter <= '0;
            r_flags   <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_divider <= n_divider;
                r_counter <= n_counter;
                r_flags   <= n_flags;
            end
            if (o_ready)
                r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meta.counter   <= n_counter;
            r_meta.flags     <= n_flags;
            r_meta.rtc_irq   <= |active;
            r_meta.alarm_irq <= active[FLAG_ALARM];
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;

endmodule

/* sv/rtc_tod.sv */
module rtc_tod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rtc_pkg::t_rtc_meta i_meta,
    output logic               o_ready,
    output logic               o_valid,
    output rtc_pkg::t_rtc_meta o_meta,
    output logic [5:0]         o_seconds,
    output logic [5:0]         o_minutes,
    output logic [4:0]         o_hours,
    input  logic               i_ready
);
    import rtc_pkg::*;

    localparam int NUM_STAGES = 6;

    logic r_valid [NUM_STAGES];
    logic en      [NUM_STAGES];

    t_rtc_meta r_meta1, r_meta2, r_meta3, r_meta4, r_meta5, r_meta6;
    logic [15:0] r_q1;
    logic [16:0] r_r2, r_r3;
    logic [4:0]  r_h3, r_h4, r_h5, r_h6;
    logic [11:0] r_rh4, r_rh5;
    logic [5:0]  r_mn5, r_mn6, r_sec6;

    logic [50:0] prod_day;
    logic [31:0] day_base;
    logic [26:0] prod_hour;
    logic [16:0] hour_base;
    logic [20:0] prod_min;
    logic [11:0] min_base;

    // a stage moves when it is empty or its successor moves
    always_comb begin
        en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES-2; k >= 0; k--)
            en[k] = !r_valid[k] || en[k+1];
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STAGES; k++)
                r_valid[k] <= 1'b0;
        end else begin
            if (en[0])
                r_valid[0] <= i_valid;
            for (int k = 1; k < NUM_STAGES; k++)
                if (en[k])
                    r_valid[k] <= r_valid[k-1];
        end
    end

    always_comb begin
        prod_day  = 51'(i_meta.counter[31:7]) * 51'(DAY_RECIP);
        day_base  = 32'(r_q1) * 32'(SEC_PER_DAY);
        prod_hour = 27'(r_r2[16:4]) * 27'(HOUR_RECIP);
        hour_base = 17'(r_h3) * 17'(SEC_PER_HOUR);
        prod_min  = 21'(r_rh4[11:2]) * 21'(MIN_RECIP);
        min_base  = 12'(r_mn5) * 12'(SEC_PER_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_meta1 <= i_meta;
            r_q1    <= prod_day[50:35];       // days
        end
        if (en[1]) begin
            r_meta2 <= r_meta1;
            r_r2    <= 17'(r_meta1.counter - day_base);   // seconds of day
        end
        if (en[2]) begin
            r_meta3 <= r_meta2;
            r_r3    <= r_r2;
            r_h3    <= prod_hour[25:21];
        end
        if (en[3]) begin
            r_meta4 <= r_meta3;
            r_h4    <= r_h3;
            r_rh4   <= 12'(r_r3 - hour_base);  // seconds of hour
        end
        if (en[4]) begin
            r_meta5 <= r_meta4;
            r_h5    <= r_h4;
            r_rh5   <= r_rh4;
            r_mn5   <= prod_min[19:14];
        end
        if (en[5]) begin
            r_meta6 <= r_meta5;
            r_h6    <= r_h5;
            r_mn6   <= r_mn5;
            r_sec6  <= 6'(r_rh5 - min_base);
        end
    end

    assign o_valid   = r_valid[NUM_STAGES-1];
    assign o_meta    = r_meta6;
    assign o_seconds = r_sec6;
    assign o_minutes = r_mn6;
    assign o_hours   = r_h6;

endmodule

/* sv/rtc_second_counter_alarm.sv */
// Real-time clock: 20-bit prescaler, 32-bit seconds counter, alarm compare.
//
// Input stream (s_axis): one request per clock tick or command. tuser holds the
// opcode (tick, load counter, clear flags, read); tdata holds the load value
// and the clear mask. Output stream (m_axis): one result per request with the
// counter, its time of day, the sticky flags and both interrupt lines.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_wdata write the prescaler
// reload, the alarm value and the interrupt enables; write only while idle.
//
// Throughput is one request per cycle while m_axis_tready is high. From acceptance
// to the result, a request passes the counter/flag update stage, then the
// time-of-day split (day, hour, minute), each unit a constant-reciprocal
// multiply stage followed by a multiply-subtract stage, registered after each.
// Each pipeline stage holds its request until the next one frees, so while
// m_axis_tready is low new requests still fill empty stages; s_axis_tready
// drops only once every stage is full.
// Reset (i_rst_n low, synchronous) loads reload 32767, alarm 0xFFFFFFFF,
// enables 0, divider 32767, counter 0, flags 0, and empties the pipeline.
module rtc_second_counter_alarm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [rtc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] load_value, [34:32] clear_mask, [39:35] zero
    input  logic [39:0]                   s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] counter_now, [37:32] time_seconds, [43:38] time_minutes,
    // [48:44] time_hours, [49] alarm_flag, [50] second_flag,
    // [51] overflow_flag, [52] rtc_irq, [53] alarm_irq, [55:54] zero
    output logic [55:0]                   m_axis_tdata
);
    import rtc_pkg::*;

    logic      core_valid;
    logic      tod_ready;
    t_rtc_meta core_meta;
    t_rtc_meta out_meta;
    logic [5:0] out_sec;
    logic [5:0] out_min;
    logic [4:0] out_hour;

    rtc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_op        (t_rtc_op'(s_axis_tuser)),
        .i_load      (s_axis_tdata[31:0]),
        .i_mask      (s_axis_tdata[34:32]),
        .o_ready     (s_axis_tready),
        .o_valid     (core_valid),
        .o_meta      (core_meta),
        .i_ready     (tod_ready)
    );

    rtc_tod u_tod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (core_valid),
        .i_meta    (core_meta),
        .o_ready   (tod_ready),
        .o_valid   (m_axis_tvalid),
        .o_meta    (out_meta),
        .o_seconds (out_sec),
        .o_minutes (out_min),
        .o_hours   (out_hour),
        .i_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00,
                           out_meta.alarm_irq,
                           out_meta.rtc_irq,
                           out_meta.flags[FLAG_OVERFLOW],
                           out_meta.flags[FLAG_SECOND],
                           out_meta.flags[FLAG_ALARM],
                           out_hour,
                           out_min,
                           out_sec,
                           out_meta.counter};

    // time-of-day split stays in range
    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[37:32] < 6'd60) && (m_axis_tdata[43:38] < 6'd60)
                          && (m_axis_tdata[48:44] < 5'd24))
        else $error("time of day out of range");

    // interrupt lines only with a matching flag
    a_irq_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[53] || m_axis_tdata[49])
                          && (!m_axis_tdata[52] || (|m_axis_tdata[51:49])))
        else $error("interrupt without flag");

    // input side only blocks when the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // zero padding of the result
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:54] == 2'b00)
        else $error("result padding not zero");

endmodule

/* dv/rtc_second_counter_alarm_tb.sv */
module rtc_second_counter_alarm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // no register behind this index
    localparam int         SPILL_MAX = 50;

    // one readout as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [1:0]           pad;
        logic                 alarm_irq;
        logic                 rtc_irq;
        logic                 overflow_flag;
        logic                 second_flag;
        logic                 alarm_flag;
        logic [4:0]           hours;
        logic [5:0]           minutes;
        logic [5:0]           seconds;
        logic [COUNTER_W-1:0] counter;
    } t_readout;

    typedef enum {ROW_ITEM, ROW_CFG, ROW_SPIN} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [1:0]           reg_idx;
        t_rtc_op              op;
        logic [31:0]          arg;     // load value, or write data on a config row
        logic [FLAGS_W-1:0]   mask;
        bit                   typed;
        t_readout             want;
    } t_script_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // [31:0] load_value, [34:32] clear_mask, [39:35] zero
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] counter_now, [37:32] time_seconds, [43:38] time_minutes, [48:44] time_hours,
    // [49] alarm_flag, [50] second_flag, [51] overflow_flag, [52] rtc_irq, [53] alarm_irq
    logic [55:0] m_axis_tdata;

    // shadow of the clock state and registers
    logic [RELOAD_W-1:0]  div_cnt;
    logic [COUNTER_W-1:0] sec_cnt;
    logic [FLAGS_W-1:0]   evt_flags;
    logic [RELOAD_W-1:0]  reload_reg;
    logic [COUNTER_W-1:0] alarm_reg;
    logic [FLAGS_W-1:0]   irq_en_reg;

    t_readout    pending_readouts[$];
    int          mismatch_count = 0;
    int          readouts_seen  = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          backpressure_kick = 1'b0;
    int          stall_left = 0;
    t_script_row script [0:32];

    rtc_second_counter_alarm DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_readout readout(logic [31:0] cnt, logic [4:0] hh, logic [5:0] mm,
                                         logic [5:0] ss, logic [2:0] flg, logic [1:0] irq);
        t_readout r;
        r               = '0;
        r.counter       = cnt;
        r.hours         = hh;
        r.minutes       = mm;
        r.seconds       = ss;
        r.alarm_flag    = flg[FLAG_ALARM];
        r.second_flag   = flg[FLAG_SECOND];
        r.overflow_flag = flg[FLAG_OVERFLOW];
        r.rtc_irq       = irq[0];
        r.alarm_irq     = irq[1];
        return r;
    endfunction

    // applies one request to the shadow state and returns what the block must show
    function automatic t_readout advance_clock(t_rtc_op op, logic [31:0] load,
                                               logic [FLAGS_W-1:0] mask);
        t_readout           r;
        logic [31:0]        day;
        logic [FLAGS_W-1:0] active;
        case (op)
            OP_TICK: begin
                if (div_cnt == '0) begin
                    div_cnt = reload_reg;
                    sec_cnt = sec_cnt + 1'b1;
                    evt_flags[FLAG_SECOND] = 1'b1;
                    if (sec_cnt == '0)
                        evt_flags[FLAG_OVERFLOW] = 1'b1;
                    if (sec_cnt == alarm_reg)
                        evt_flags[FLAG_ALARM] = 1'b1;
                end else begin
                    div_cnt = div_cnt - 1'b1;
                end
            end
            OP_LOAD:  sec_cnt = load;
            OP_CLEAR: evt_flags = evt_flags & ~mask;
            default: ;
        endcase
        day    = sec_cnt % SEC_PER_DAY;
        active = evt_flags & irq_en_reg;
        r               = '0;
        r.counter       = sec_cnt;
        r.seconds       = 6'(day % SEC_PER_MIN);
        r.minutes       = 6'((day % SEC_PER_HOUR) / SEC_PER_MIN);
        r.hours         = 5'(day / SEC_PER_HOUR);
        r.alarm_flag    = evt_flags[FLAG_ALARM];
        r.second_flag   = evt_flags[FLAG_SECOND];
        r.overflow_flag = evt_flags[FLAG_OVERFLOW];
        r.rtc_irq       = |active;
        r.alarm_irq     = active[FLAG_ALARM];
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        if (mismatch_count < SPILL_MAX)
            $display("%0t: readout %0d %s: got 0x%0h, want 0x%0h",
                     $time, readouts_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_readout(t_readout got, t_readout want);
        if (got.counter !== want.counter)
            flag_mismatch("counter_now", got.counter, want.counter);
        if (got.seconds !== want.seconds)
            flag_mismatch("time_seconds", got.seconds, want.seconds);
        if (got.minutes !== want.minutes)
            flag_mismatch("time_minutes", got.minutes, want.minutes);
        if (got.hours !== want.hours)
            flag_mismatch("time_hours", got.hours, want.hours);
        if (got.alarm_flag !== want.alarm_flag)
            flag_mismatch("alarm_flag", got.alarm_flag, want.alarm_flag);
        if (got.second_flag !== want.second_flag)
            flag_mismatch("second_flag", got.second_flag, want.second_flag);
        if (got.overflow_flag !== want.overflow_flag)
            flag_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
        if (got.rtc_irq !== want.rtc_irq)
            flag_mismatch("rtc_irq", got.rtc_irq, want.rtc_irq);
        if (got.alarm_irq !== want.alarm_irq)
            flag_mismatch("alarm_irq", got.alarm_irq, want.alarm_irq);
        if (got.pad !== want.pad)
            flag_mismatch("padding", got.pad, want.pad);
    endtask

    // result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (backpressure_kick) begin
            backpressure_kick = 1'b0;
            stall_left = 250;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readouts.size() == 0)
                flag_mismatch("unexpected readout", m_axis_tdata, 0);
            else
                compare_readout(t_readout'(m_axis_tdata), pending_readouts.pop_front());
            readouts_seen++;
        end
    end

    // entered just after a falling edge; returns at the falling edge after acceptance
    task automatic send_request(t_rtc_op op, logic [31:0] load, logic [FLAGS_W-1:0] mask,
                                bit typed, t_readout want);
        t_readout expect_now;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 40'({$urandom, $urandom});
            s_axis_tuser  <= 2'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, mask, load};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        expect_now = advance_clock(op, load, mask);
        pending_readouts.push_back(typed ? want : expect_now);
        @(negedge i_clk);
    endtask

    // stop offering and let every outstanding request come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_readouts.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RELOAD: reload_reg = data[RELOAD_W-1:0];
            CFG_ALARM:  alarm_reg  = data;
            CFG_IRQ_EN: irq_en_reg = data[FLAGS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic random_request(output t_rtc_op op, output logic [31:0] load,
                                  output logic [FLAGS_W-1:0] mask);
        int pick;
        pick = $urandom_range(99);
        load = $urandom;
        mask = 3'($urandom);
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 70)
            op = OP_LOAD;
        else if (pick < 85)
            op = OP_CLEAR;
        else
            op = OP_READ;
        if (op == OP_LOAD) begin
            // in half the loads, land on or just short of the alarm, the wrap or a day boundary
            case ($urandom_range(5))
                0: load = alarm_reg - $urandom_range(6);
                1: load = 32'hFFFF_FFFF - $urandom_range(6);
                2: load = 32'd86400 * $urandom_range(49710) - $urandom_range(3);
                default: ;
            endcase
        end
    endtask

    initial begin
        t_rtc_op            op;
        logic [31:0]        load;
        logic [FLAGS_W-1:0] mask;
        logic [31:0]        wdata;
        int                 n_items;

        div_cnt    = RELOAD_RST;
        sec_cnt    = '0;
        evt_flags  = '0;
        reload_reg = RELOAD_RST;
        alarm_reg  = ALARM_RST;
        irq_en_reg = '0;

        script = '{
            '{ROW_ITEM, CFG_SPARE, OP_READ,  32'h0,         3'h0, 1'b1,
              readout(32'h0, 5'd0, 6'd0, 6'd0, 3'b000, 2'b00)},
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'hFFFF_FFFF, 3'h7, 1'b1,
              readout(32'h0, 5'd0, 6'd0, 6'd0, 3'b000, 2'b00)},
            '{ROW_ITEM, CFG_SPARE, OP_LOAD,  32'hFFFF_FFFF, 3'h7, 1'b1,
              readout(32'hFFFF_FFFF, 5'd6, 6'd28, 6'd15, 3'b000, 2'b00)},
            '{ROW_ITEM, CFG_SPARE, OP_CLEAR, 32'h1234_5678, 3'h7, 1'b1,
              readout(32'hFFFF_FFFF, 5'd6, 6'd28, 6'd15, 3'b000, 2'b00)},
            '{ROW_CFG,  CFG_RELOAD, OP_READ, 32'h0,         3'h0, 1'b0, '0},
            '{ROW_CFG,  CFG_ALARM,  OP_READ, 32'h0,         3'h0, 1'b0, '0},
            '{ROW_CFG,  CFG_IRQ_EN, OP_READ, 32'h7,         3'h0, 1'b0, '0},
            // divider still runs out the reset period before the new reload applies
            '{ROW_SPIN, CFG_SPARE, OP_TICK,  32'h0,         3'h0, 1'b0, '0},
            // wrap to zero with alarm at zero: all three flags at once
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'h0,         3'h0, 1'b1,
              readout(32'h0, 5'd0, 6'd0, 6'd0, 3'b111, 2'b11)},
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'hAAAA_AAAA, 3'h5, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_CLEAR, 32'h5555_5555, 3'h1, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_CLEAR, 32'h0,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_LOAD,  32'd86399,     3'h2, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'h0,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_CLEAR, 32'h0,         3'h7, 1'b0, '0},
            '{ROW_CFG,  CFG_ALARM,  OP_READ, 32'd86402,     3'h0, 1'b0, '0},
            '{ROW_CFG,  CFG_IRQ_EN, OP_READ, 32'h1,         3'h0, 1'b0, '0},
            // a load onto the alarm value must not raise it
            '{ROW_ITEM, CFG_SPARE, OP_LOAD,  32'd86402,     3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_LOAD,  32'd86401,     3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'h0,         3'h0, 1'b0, '0},
            '{ROW_CFG,  CFG_IRQ_EN, OP_READ, 32'h2,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_READ,  32'hFFFF_FFFF, 3'h7, 1'b0, '0},
            '{ROW_CFG,  CFG_IRQ_EN, OP_READ, 32'h4,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_READ,  32'h0,         3'h0, 1'b0, '0},
            '{ROW_CFG,  CFG_SPARE,  OP_READ, 32'hFFFF_FFFF, 3'h0, 1'b0, '0},
            // widest reload, replaced again before any tick can pick it up
            '{ROW_CFG,  CFG_RELOAD, OP_READ, 32'hFFFF_FFFF, 3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_LOAD,  32'hFFFF_FFFE, 3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_CLEAR, 32'h0,         3'h6, 1'b0, '0},
            '{ROW_CFG,  CFG_RELOAD, OP_READ, 32'h1,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'h0,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'h0,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_TICK,  32'h0,         3'h0, 1'b0, '0},
            '{ROW_ITEM, CFG_SPARE, OP_READ,  32'h0,         3'h0, 1'b0, '0}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_ITEM: send_request(script[i].op, script[i].arg, script[i].mask,
                                       script[i].typed, script[i].want);
                ROW_CFG: begin
                    settle();
                    write_reg(script[i].reg_idx, script[i].arg);
                end
                default: begin
                    while (div_cnt != '0)
                        send_request(OP_TICK, $urandom, 3'($urandom), 1'b0, '0);
                end
            endcase
        end

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            wdata = $urandom;
            wdata[RELOAD_W-1:0] = (ph == 0) ? '0 : (ph == 1) ? 20'd3 : 20'($urandom_range(2));
            write_reg(CFG_RELOAD, wdata);
            write_reg(CFG_ALARM, (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'h0 : $urandom);
            write_reg(CFG_IRQ_EN, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            n_items = 205;
            for (int i = 0; i < n_items; i++) begin
                if (ph == 4 && i == n_items / 3)
                    backpressure_kick = 1'b1;
                if ((ph == 5 || ph == 1) && i == n_items / 2)
                    settle();
                random_request(op, load, mask);
                send_request(op, load, mask, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/rtc_pkg.sv
sv/rtc_core.sv
sv/rtc_tod.sv
sv/rtc_second_counter_alarm.sv
dv/rtc_second_counter_alarm_tb.sv
